[rtl/nss_pkg.sv]
// Shared types and constants for the nearest-station search block.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
package nss_pkg;
   localparam int STATIONS   = 16;
   localparam int COORD_W    = 16;
   localparam int SLOT_W     = 4;
   localparam int DIST_W     = 17;
   localparam int SQ_W       = 34;
   localparam int DIV_W      = 33;
   localparam int DVSR_W     = 16;
   localparam int COST_W     = 32;
   localparam int PROD_W     = DIV_W + DVSR_W;
   localparam int MODE_W     = 4;
   localparam int COUNT_W    = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int STATUS_W   = 2;

   localparam logic [COST_W-1:0] COST_MAX = '1;

   localparam logic [MODE_W-1:0] MODE_NONE                = 4'd0;
   localparam logic [MODE_W-1:0] MODE_EUCLID_TIME         = 4'd3;
   localparam logic [MODE_W-1:0] MODE_EUCLID_ENERGY       = 4'd5;
   localparam logic [MODE_W-1:0] MODE_EUCLID_TIME_ENERGY  = 4'd7;
   localparam logic [MODE_W-1:0] MODE_MANHAT_TIME_ENERGY  = 4'd8;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_METRIC = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNIMPL    = 2'd2;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_METRIC_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STATION_COUNT = 2'd1;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } station_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [DVSR_W-1:0] divisor;
   } div_req_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_FRAC, ST_HEAD, ST_DIST, ST_SQRT, ST_TIME,
      ST_DIVW, ST_MUL, ST_SCALE, ST_CMP, ST_OUT
   } state_type;
endpackage

[rtl/nss_cell.sv]
// One station cell of the rotating station ring.
// Depends on nss_pkg for the station type.
`timescale 1ns / 1ps
module nss_cell
   import nss_pkg::*;
(
   input  logic        clock,
   input  logic        wr_en,
   input  station_type wr_station,
   input  logic        shift,
   input  station_type next_station,
   output station_type station
);
   station_type station_ff, station_in;

   always_comb begin
      station_in = station_ff;
      if (wr_en) begin
         station_in = wr_station;
      end else if (shift) begin
         station_in = next_station;
      end
   end

   always_ff @(posedge clock) begin
      station_ff <= station_in;
   end

   assign station = station_ff;
endmodule

[rtl/nss_sqrt.sv]
// Bit-serial integer square root, rounded half up; a new start restarts it mid-root.
// Depends on nss_pkg for widths.
`timescale 1ns / 1ps
module nss_sqrt
   import nss_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SQ_W-1:0]   radicand,
   output logic              done,
   output logic [DIST_W-1:0] root
);
   logic [SQ_W-1:0] v_ff, v_in, r_ff, r_in, bit_ff, bit_in, trial;
   logic            busy_ff, busy_in, done_ff, done_in;
   logic [SQ_W-1:0] rounded;

   always_comb begin
      v_in    = v_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = r_ff + bit_ff;
      if (start) begin
         v_in    = radicand;
         r_in    = '0;
         bit_in  = SQ_W'(64'd1 << (SQ_W - 2));
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == SQ_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      v_ff   <= v_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign rounded = (v_ff > r_ff) ? r_ff + SQ_W'(1) : r_ff;
   assign done    = done_ff;
   assign root    = rounded[DIST_W-1:0];
endmodule

[rtl/nss_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on nss_pkg for widths and the request struct.
`timescale 1ns / 1ps
module nss_div
   import nss_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  div_req_type      req,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);
   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0]  q_ff, q_in;
   logic [DVSR_W-1:0] rem_ff, rem_in, dvsr_ff, dvsr_in;
   logic [DVSR_W:0]   rem_sh;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff, q_ff[DIV_W-1]};
      if (req.start) begin
         q_in    = req.dividend;
         rem_in  = '0;
         dvsr_in = req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvsr_ff}) begin
            rem_in = DVSR_W'(rem_sh - {1'b0, dvsr_ff});
            q_in   = {q_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DVSR_W-1:0];
            q_in   = {q_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
      cnt_ff  <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;
endmodule

[rtl/nearest_station_search.sv]
// Nearest-station search top level: station ring, cost sequencer, result register.
// Depends on nss_pkg, nss_cell, nss_sqrt and nss_div.
`timescale 1ns / 1ps
// A write transfer stores one station. A query with a defined, implemented
// metric rotates the station ring through all STATIONS cells, one cell per
// step, costing the head cell while its index lies below station_count. The
// battery fraction is divided out first unless it is full; each scanned
// station then takes a Euclidean root if the metric needs one, and the speed
// divide and battery scaling as its mode asks. The fraction and speed divides
// share one one-bit-per-cycle divider. One query is in flight at a time; the
// result register lets a new transfer in while the last result waits.
module nearest_station_search
   import nss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_cmd,
   input  logic [SLOT_W-1:0]     req_station_slot,
   input  logic [COORD_W-1:0]    req_pos_x,
   input  logic [COORD_W-1:0]    req_pos_y,
   input  logic [15:0]           req_robot_speed,
   input  logic [15:0]           req_battery_load,
   input  logic [15:0]           req_battery_runtime,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SLOT_W-1:0]     rsp_best_slot,
   output logic                  rsp_found,
   output logic [COST_W-1:0]     rsp_best_cost,
   output logic [STATUS_W-1:0]   rsp_status,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int CNT_W = $clog2(STATIONS + 1);

   station_type ring [STATIONS];
   station_type wr_station;
   logic        shift, accept, wr_req;

   state_type state_ff, state_in;
   logic [MODE_W-1:0]  mode_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [COORD_W-1:0] px_ff, px_in, py_ff, py_in, dx_ff, dx_in, dy_ff, dy_in;
   logic [15:0]        speed_ff, speed_in, frac_ff, frac_in;
   logic               frac_full_ff, frac_full_in;
   logic               euclid_ff, euclid_in, time_ff, time_in, energy_ff, energy_in;
   logic [DIST_W-1:0]  d_ff, d_in;
   logic [DIV_W-1:0]   t_ff, t_in, scaled;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [COST_W-1:0]  cost_ff, cost_in, best_ff, best_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic               found_ff, found_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in, rsp_load;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   logic               rsp_found_ff;
   logic [COST_W-1:0]  rsp_cost_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   div_req_type        div_req;
   logic               div_done, sqrt_start, sqrt_done;
   logic [DIV_W-1:0]   div_quot;
   logic [DIST_W-1:0]  sqrt_root;
   logic [SQ_W-1:0]    radicand;

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid & req_ready;
   assign wr_req     = accept & (req_cmd == CMD_WRITE);
   assign wr_station = '{x: req_pos_x, y: req_pos_y};
   assign csr_ready  = 1'b1;

   for (genvar i = 0; i < STATIONS; i++) begin : g_ring
      nss_cell u_cell (
         .clock        (clock),
         .wr_en        (wr_req && ({28'd0, req_station_slot} == 32'(i))),
         .wr_station   (wr_station),
         .shift        (shift),
         .next_station (ring[(i + 1) % STATIONS]),
         .station      (ring[i])
      );
   end

   assign radicand = SQ_W'(32'(dx_ff) * 32'(dx_ff)) + SQ_W'(32'(dy_ff) * 32'(dy_ff));

   nss_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (radicand),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   nss_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign scaled = frac_full_ff ? t_ff : prod_ff[PROD_W-1:16];

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      speed_in     = speed_ff;
      frac_in      = frac_ff;
      frac_full_in = frac_full_ff;
      euclid_in    = euclid_ff;
      time_in      = time_ff;
      energy_in    = energy_ff;
      d_in         = d_ff;
      t_in         = t_ff;
      prod_in      = prod_ff;
      cost_in      = cost_ff;
      best_in      = best_ff;
      slot_in      = slot_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      shift        = 1'b0;
      sqrt_start   = 1'b0;
      rsp_load     = 1'b0;
      div_req      = '{start: 1'b0, dividend: '0, divisor: '0};
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_cmd == CMD_QUERY)) begin
               px_in     = req_pos_x;
               py_in     = req_pos_y;
               speed_in  = req_robot_speed;
               euclid_in = mode_ff[0];
               time_in   = (mode_ff >= MODE_EUCLID_TIME);
               energy_in = (mode_ff >= MODE_EUCLID_ENERGY);
               idx_in    = '0;
               best_in   = COST_MAX;
               slot_in   = '0;
               found_in  = 1'b0;
               status_in = STATUS_OK;
               if ((mode_ff == MODE_NONE) || (mode_ff > MODE_MANHAT_TIME_ENERGY)) begin
                  status_in = STATUS_NO_METRIC;
                  state_in  = ST_OUT;
               end else if (mode_ff >= MODE_EUCLID_TIME_ENERGY) begin
                  status_in = STATUS_UNIMPL;
                  state_in  = ST_OUT;
               end else if ((req_battery_runtime == '0) ||
                            (req_battery_load >= req_battery_runtime)) begin
                  frac_full_in = 1'b1;
                  state_in     = ST_HEAD;
               end else begin
                  frac_full_in = 1'b0;
                  div_req      = '{start: 1'b1,
                                   dividend: {1'b0, req_battery_load, 16'd0},
                                   divisor: req_battery_runtime};
                  state_in     = ST_FRAC;
               end
            end
         end
         ST_FRAC: begin
            if (div_done) begin
               frac_in  = div_quot[15:0];
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            if (idx_ff == CNT_W'(STATIONS)) begin
               state_in = ST_OUT;
            end else if (32'(idx_ff) < 32'(count_ff)) begin
               dx_in    = (px_ff > ring[0].x) ? px_ff - ring[0].x : ring[0].x - px_ff;
               dy_in    = (py_ff > ring[0].y) ? py_ff - ring[0].y : ring[0].y - py_ff;
               state_in = ST_DIST;
            end else begin
               shift  = 1'b1;
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ST_DIST: begin
            if (euclid_ff) begin
               sqrt_start = 1'b1;
               state_in   = ST_SQRT;
            end else begin
               d_in     = DIST_W'(dx_ff) + DIST_W'(dy_ff);
               state_in = ST_TIME;
            end
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               d_in     = sqrt_root;
               state_in = ST_TIME;
            end
         end
         ST_TIME: begin
            if (!time_ff) begin
               cost_in  = {7'd0, d_ff, 8'd0};
               state_in = ST_CMP;
            end else if (speed_ff == '0) begin
               cost_in  = COST_MAX;
               state_in = ST_CMP;
            end else begin
               div_req  = '{start: 1'b1, dividend: {d_ff, 16'd0}, divisor: speed_ff};
               state_in = ST_DIVW;
            end
         end
         ST_DIVW: begin
            if (div_done) begin
               t_in = div_quot;
               if (!energy_ff) begin
                  cost_in  = div_quot[DIV_W-1] ? COST_MAX : div_quot[COST_W-1:0];
                  state_in = ST_CMP;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(t_ff) * PROD_W'(frac_ff);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cost_in  = scaled[DIV_W-1] ? COST_MAX : scaled[COST_W-1:0];
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (cost_ff < best_ff) begin
               best_in  = cost_ff;
               slot_in  = SLOT_W'(idx_ff);
               found_in = 1'b1;
            end
            shift    = 1'b1;
            idx_in   = idx_ff + CNT_W'(1);
            state_in = ST_HEAD;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_NONE;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_METRIC_MODE) begin
               mode_ff <= csr_wdata[MODE_W-1:0];
            end else if (csr_index == CSR_STATION_COUNT) begin
               count_ff <= csr_wdata[COUNT_W-1:0];
            end
         end
      end
      idx_ff       <= idx_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      speed_ff     <= speed_in;
      frac_ff      <= frac_in;
      frac_full_ff <= frac_full_in;
      euclid_ff    <= euclid_in;
      time_ff      <= time_in;
      energy_ff    <= energy_in;
      d_ff         <= d_in;
      t_ff         <= t_in;
      prod_ff      <= prod_in;
      cost_ff      <= cost_in;
      best_ff      <= best_in;
      slot_ff      <= slot_in;
      found_ff     <= found_in;
      status_ff    <= status_in;
      if (rsp_load) begin
         rsp_slot_ff   <= slot_ff;
         rsp_found_ff  <= found_ff;
         rsp_cost_ff   <= best_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_best_slot = rsp_slot_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_best_cost = rsp_cost_ff;
   assign rsp_status    = rsp_status_ff;
endmodule

[rtl/nss_checker.sv]
// Port-level checks for the nearest-station search block, bound to the top level.
// Depends on nss_pkg and nearest_station_search.
`timescale 1ns / 1ps
module nss_checker
   import nss_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [SLOT_W-1:0]   rsp_best_slot,
   input logic                rsp_found,
   input logic [COST_W-1:0]   rsp_best_cost,
   input logic [STATUS_W-1:0] rsp_status
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_best_cost))
      else $error("result dropped before transfer");

   a_miss_cost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_best_cost == COST_MAX && rsp_best_slot == '0)
      else $error("miss carries cost or slot");

   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == STATUS_OK && rsp_best_cost != COST_MAX)
      else $error("hit with bad status or saturated cost");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STATUS_OK || rsp_status == STATUS_NO_METRIC ||
                    rsp_status == STATUS_UNIMPL)
      else $error("undefined status");
endmodule

bind nearest_station_search nss_checker u_nss_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_best_slot (rsp_best_slot),
   .rsp_found     (rsp_found),
   .rsp_best_cost (rsp_best_cost),
   .rsp_status    (rsp_status)
);

[sim/nearest_station_search_tb.sv]
// Self-checking testbench for nearest_station_search: station writes, queries over all metrics.
// Predicts each query result in a scoreboard class; depends on nss_pkg and the block RTL.
`timescale 1ns / 1ps
module nearest_station_search_tb;
   import nss_pkg::*;

   localparam logic [MODE_W-1:0] MODE_EUCLID        = 4'd1;
   localparam logic [MODE_W-1:0] MODE_MANHAT        = 4'd2;
   localparam logic [MODE_W-1:0] MODE_MANHAT_TIME   = 4'd4;
   localparam logic [MODE_W-1:0] MODE_MANHAT_ENERGY = 4'd6;
   localparam int NUM_STATIONS = STATIONS;

   typedef struct {
      logic [SLOT_W-1:0]   slot;
      logic                found;
      logic [COST_W-1:0]   cost;
      logic [STATUS_W-1:0] status;
   } search_result_type;

   class station_search_scoreboard;
      logic [MODE_W-1:0]  mode;
      logic [COUNT_W-1:0] count;
      logic [15:0]        tab_x [NUM_STATIONS];
      logic [15:0]        tab_y [NUM_STATIONS];
      search_result_type  pending_results [$];
      int                 errors;

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_METRIC_MODE) mode = data[MODE_W-1:0];
         else if (idx == CSR_STATION_COUNT) count = data[COUNT_W-1:0];
      endfunction

      function longint unsigned round_root(longint unsigned s);
         longint unsigned r;
         r = 0;
         for (int b = 31; b >= 0; b--) begin
            longint unsigned c;
            c = r | (64'd1 << b);
            if (c * c <= s) r = c;
         end
         if (s - r * r > r) r++;
         return r;
      endfunction

      function logic [COST_W-1:0] sat(longint unsigned v);
         return (v > 64'hFFFF_FFFF) ? COST_MAX : v[31:0];
      endfunction

      function logic [COST_W-1:0] station_cost(int i, logic [15:0] qx, logic [15:0] qy,
                                               logic [15:0] spd, longint unsigned frac);
         longint unsigned dx, dy, d, t;
         dx = (qx > tab_x[i]) ? 64'(qx - tab_x[i]) : 64'(tab_x[i] - qx);
         dy = (qy > tab_y[i]) ? 64'(qy - tab_y[i]) : 64'(tab_y[i] - qy);
         d = mode[0] ? round_root(dx * dx + dy * dy) : dx + dy;
         if (mode < MODE_EUCLID_TIME) return sat(d << 8);
         if (spd == 0) return COST_MAX;
         t = (d << 16) / spd;
         if (mode < MODE_EUCLID_ENERGY) return sat(t);
         return sat((t * frac) >> 16);
      endfunction

      function void note_request(logic cmd, logic [SLOT_W-1:0] slot, logic [15:0] px,
                                 logic [15:0] py, logic [15:0] spd, logic [15:0] ld,
                                 logic [15:0] rt);
         search_result_type res;
         longint unsigned frac;
         logic [COST_W-1:0] c;
         int n;
         if (cmd == CMD_WRITE) begin
            tab_x[slot] = px;
            tab_y[slot] = py;
            return;
         end
         res.slot = 0;
         res.found = 0;
         res.cost = COST_MAX;
         res.status = STATUS_OK;
         if (mode == MODE_NONE || mode > MODE_MANHAT_TIME_ENERGY) begin
            res.status = STATUS_NO_METRIC;
         end else if (mode >= MODE_EUCLID_TIME_ENERGY) begin
            res.status = STATUS_UNIMPL;
         end else begin
            if (rt == 0) frac = 65536;
            else begin
               frac = (longint'(ld) << 16) / rt;
               if (frac > 65536) frac = 65536;
            end
            n = (count > NUM_STATIONS) ? NUM_STATIONS : int'(count);
            for (int i = 0; i < n; i++) begin
               c = station_cost(i, px, py, spd, frac);
               if (c < res.cost) begin
                  res.cost = c;
                  res.slot = SLOT_W'(i);
                  res.found = 1;
               end
            end
         end
         pending_results.insert(pending_results.size(), res);
      endfunction

      function void check_response(logic [SLOT_W-1:0] slot, logic found,
                                   logic [COST_W-1:0] cost, logic [STATUS_W-1:0] status);
         search_result_type e;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result slot=%0d found=%0d cost=%h status=%0d",
                     $realtime, slot, found, cost, status);
            errors++;
            return;
         end
         e = pending_results.pop_front();
         if (slot !== e.slot) begin
            $display("%0t: best_slot expected %0d actual %0d", $realtime, e.slot, slot);
            errors++;
         end
         if (found !== e.found) begin
            $display("%0t: found expected %0d actual %0d", $realtime, e.found, found);
            errors++;
         end
         if (cost !== e.cost) begin
            $display("%0t: best_cost expected %h actual %h", $realtime, e.cost, cost);
            errors++;
         end
         if (status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, e.status, status);
            errors++;
         end
      endfunction
   endclass

   logic                  clock, reset;
   logic                  req_valid, req_ready, req_cmd;
   logic [SLOT_W-1:0]     req_station_slot;
   logic [COORD_W-1:0]    req_pos_x, req_pos_y;
   logic [15:0]           req_robot_speed, req_battery_load, req_battery_runtime;
   logic                  rsp_valid, rsp_ready, rsp_found;
   logic [SLOT_W-1:0]     rsp_best_slot;
   logic [COST_W-1:0]     rsp_best_cost;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   station_search_scoreboard sb = new();
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;

   nearest_station_search DUT (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_cmd, req_station_slot, req_pos_x, req_pos_y,
                            req_robot_speed, req_battery_load, req_battery_runtime);
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_best_slot, rsp_found, rsp_best_cost, rsp_status);
         if (csr_valid && csr_ready)
            sb.set_register(csr_index, csr_wdata);
      end
   end

   function automatic logic [15:0] pick16();
      int r;
      r = $urandom_range(7);
      if (r == 0) return 16'h0000;
      if (r == 1) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   task automatic send_request(logic cmd, logic [SLOT_W-1:0] slot, logic [15:0] px,
                               logic [15:0] py, logic [15:0] spd, logic [15:0] ld,
                               logic [15:0] rt);
      if (req_valid && $urandom_range(99) < tx_idle_pct) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1;
      req_cmd <= cmd;
      req_station_slot <= slot;
      req_pos_x <= px;
      req_pos_y <= py;
      req_robot_speed <= spd;
      req_battery_load <= ld;
      req_battery_runtime <= rt;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold the sender until every expected result has come
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic configure(int mode, int count);
      drain();
      csr_write(CSR_METRIC_MODE, mode);
      csr_write(CSR_STATION_COUNT, count);
   endtask

   task automatic random_query();
      send_request(CMD_QUERY, SLOT_W'($urandom), pick16(), pick16(),
                   ($urandom_range(5) == 0) ? 16'($urandom_range(2)) : pick16(),
                   pick16(), pick16());
   endtask

   initial begin
      int mode, count, r;
      reset <= 1;
      req_valid <= 0;
      req_cmd <= CMD_WRITE;
      req_station_slot <= 0;
      req_pos_x <= 0;
      req_pos_y <= 0;
      req_robot_speed <= 0;
      req_battery_load <= 0;
      req_battery_runtime <= 0;
      csr_valid <= 0;
      csr_index <= CSR_METRIC_MODE;
      csr_wdata <= 0;
      sb.mode = MODE_NONE;
      sb.count = 0;
      repeat (3) @(posedge clock);
      reset <= 0;

      // directed: reset defaults, empty table, table fill, each mode and edge case
      send_request(CMD_QUERY, 0, 0, 0, 16'h0100, 0, 0);
      configure(MODE_EUCLID, 0);
      send_request(CMD_QUERY, 0, 16'h1234, 16'h4321, 16'h0100, 0, 0);
      send_request(CMD_WRITE, 0, 16'h0000, 16'h0000, 0, 0, 0);
      send_request(CMD_WRITE, 1, 16'h0000, 16'h0000, 0, 0, 0);
      for (int i = 2; i < 15; i++)
         send_request(CMD_WRITE, SLOT_W'(i), 16'($urandom), 16'($urandom), 0, 0, 0);
      send_request(CMD_WRITE, 15, 16'hFFFF, 16'hFFFF, 0, 0, 0);
      configure(MODE_EUCLID, 16);
      send_request(CMD_QUERY, 0, 16'hFFFF, 16'h0000, 16'h0100, 0, 0);
      configure(MODE_MANHAT, 31);
      send_request(CMD_QUERY, 0, 16'hFFFF, 16'hFFFF, 16'h0100, 0, 0);
      configure(MODE_EUCLID_TIME, 16);
      send_request(CMD_QUERY, 0, 16'h8000, 16'h8000, 16'h0000, 0, 0);
      configure(MODE_MANHAT_TIME, 16);
      send_request(CMD_QUERY, 0, 16'h0000, 16'hFFFF, 16'h0001, 0, 0);
      configure(MODE_EUCLID_ENERGY, 16);
      send_request(CMD_QUERY, 0, 16'h7000, 16'h1000, 16'hFFFF, 16'h1234, 16'h0000);
      configure(MODE_MANHAT_ENERGY, 16);
      send_request(CMD_QUERY, 0, 16'h0100, 16'h0200, 16'h0080, 16'hFFFF, 16'h0001);
      configure(MODE_EUCLID_TIME_ENERGY, 16);
      send_request(CMD_QUERY, 0, 0, 0, 16'h0100, 1, 2);
      configure(MODE_MANHAT_TIME_ENERGY, 16);
      send_request(CMD_QUERY, 0, 0, 0, 16'h0100, 1, 2);
      configure(15, 16);
      send_request(CMD_QUERY, 0, 0, 0, 16'h0100, 1, 2);

      // random phases: receiver idles more, then sender idles more, then neither
      for (int ph = 0; ph < 6; ph++) begin
         tx_idle_pct = (ph < 2) ? 30 : (ph < 4) ? 45 : 0;
         rx_idle_pct = (ph < 2) ? 45 : (ph < 4) ? 30 : 0;
         mode = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(1, 6);
         r = $urandom_range(9);
         count = (r < 6) ? $urandom_range(0, 4) : (r < 8) ? $urandom_range(5, 16) :
                 (r == 8) ? 16 : $urandom_range(17, 31);
         if (ph == 0) mode = MODE_MANHAT_ENERGY;
         configure(mode, count);
         for (int k = 0; k < 100; k++) begin
            if (ph == 1 && k == 50) drain();
            if ($urandom_range(4) == 0)
               send_request(CMD_WRITE, SLOT_W'($urandom), pick16(), pick16(),
                            16'($urandom), 16'($urandom), 16'($urandom));
            else
               random_query();
         end
      end

      drain();
      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.pending_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
